>>> design/via_pkg.sv
// types and constants shared by the interface adapter
package via_pkg;

   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_READ  = 3'd1;
   localparam logic [2:0] CMD_TICK  = 3'd2;
   localparam logic [2:0] CMD_CA1   = 3'd3;
   localparam logic [2:0] CMD_MOUSE = 3'd4;

   localparam logic [3:0] REG_ORB   = 4'd0;
   localparam logic [3:0] REG_ORA   = 4'd1;
   localparam logic [3:0] REG_DDRB  = 4'd2;
   localparam logic [3:0] REG_DDRA  = 4'd3;
   localparam logic [3:0] REG_T1CL  = 4'd4;
   localparam logic [3:0] REG_T1CH  = 4'd5;
   localparam logic [3:0] REG_T1LL  = 4'd6;
   localparam logic [3:0] REG_T1LH  = 4'd7;
   localparam logic [3:0] REG_T2CL  = 4'd8;
   localparam logic [3:0] REG_T2CH  = 4'd9;
   localparam logic [3:0] REG_ACR   = 4'd11;
   localparam logic [3:0] REG_PCR   = 4'd12;
   localparam logic [3:0] REG_IFR   = 4'd13;
   localparam logic [3:0] REG_IER   = 4'd14;
   localparam logic [3:0] REG_ORANH = 4'd15;

   localparam logic CSR_MOUSE_ENABLE = 1'b0;
   localparam logic CSR_BOTH_MIDDLE  = 1'b1;

   localparam int CNT_W = 19;

   typedef struct packed {
      logic [2:0]         command;
      logic [3:0]         address;
      logic [7:0]         write_data;
      logic [7:0]         elapsed_cycles;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic [2:0]         mouse_buttons;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic [7:0] port_a_out;
      logic [7:0] port_b_out;
      logic       mouse_pending;
   } rsp_type;

endpackage

>>> design/versatile_interface_adapter_core.sv
// 6522-style interface adapter with timers and quadrature mouse
// the rsp beat is registered and appears in the cycle after its req beat is accepted
// throughput: one beat per cycle while rsp_ready holds, state updated in the accepting cycle
// a single register-file update lies between req port and result register
// reset: synchronous active high, state registers (not rsp data) to power-on values, counters 131070
module versatile_interface_adapter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  via_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output via_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic             csr_wdata
);
   import via_pkg::*;

   logic mouse_en_ff, both_mid_ff;
   logic [7:0] out_a_ff, out_b_ff, pins_b_ff, dir_a_ff, dir_b_ff, acr_ff, pcr_ff, ifr_ff;
   logic [6:0] ier_ff;
   logic [15:0] t1_latch_ff, t2_latch_ff;
   logic signed [CNT_W-1:0] t1_cnt_ff, t2_cnt_ff;
   logic t1_fired_ff, t2_phase_ff;
   logic signed [15:0] mx_ff, my_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic [7:0] out_a_in, out_b_in, pins_b_in, dir_a_in, dir_b_in, acr_in, pcr_in, ifr_in;
   logic [6:0] ier_in;
   logic [15:0] t1_latch_in, t2_latch_in;
   logic signed [CNT_W-1:0] t1_cnt_in, t2_cnt_in;
   logic t1_fired_in, t2_phase_in;
   logic signed [15:0] mx_in, my_in;
   rsp_type rsp_in;
   logic accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [7:0] rd, v;
      logic [2:0] b;
      logic signed [CNT_W:0] c1, c2, n1;
      logic signed [CNT_W:0] l1x2, l2x2;
      logic signed [CNT_W-1:0] t1_h, t1_k, t2_h, t2_k;
      out_a_in = out_a_ff; out_b_in = out_b_ff; pins_b_in = pins_b_ff;
      dir_a_in = dir_a_ff; dir_b_in = dir_b_ff; acr_in = acr_ff; pcr_in = pcr_ff;
      ifr_in = ifr_ff; ier_in = ier_ff;
      t1_latch_in = t1_latch_ff; t2_latch_in = t2_latch_ff;
      t1_cnt_in = t1_cnt_ff; t2_cnt_in = t2_cnt_ff;
      t1_fired_in = t1_fired_ff; t2_phase_in = t2_phase_ff;
      mx_in = mx_ff; my_in = my_ff;
      rd = 8'hff;
      v = req_data.write_data;
      b = req_data.mouse_buttons;
      l1x2 = $signed({3'b000, t1_latch_ff, 1'b0});
      l2x2 = $signed({3'b000, t2_latch_ff, 1'b0});
      // counter halves and 512ths, rounded toward zero
      t1_h = (t1_cnt_ff + (t1_cnt_ff[CNT_W-1] ? 19'sd1 : 19'sd0)) >>> 1;
      t1_k = (t1_cnt_ff + (t1_cnt_ff[CNT_W-1] ? 19'sd511 : 19'sd0)) >>> 9;
      t2_h = (t2_cnt_ff + (t2_cnt_ff[CNT_W-1] ? 19'sd1 : 19'sd0)) >>> 1;
      t2_k = (t2_cnt_ff + (t2_cnt_ff[CNT_W-1] ? 19'sd511 : 19'sd0)) >>> 9;
      c1 = t1_cnt_ff - $signed({12'd0, req_data.elapsed_cycles});
      c2 = t2_cnt_ff - $signed({12'd0, req_data.elapsed_cycles});
      n1 = l1x2 + c1 + 20'sd4;
      case (req_data.command)
         CMD_WRITE: begin
            case (req_data.address)
               REG_ORB: begin
                  out_b_in = v;
                  if (!pcr_ff[1]) ifr_in[0] = 1'b0;
               end
               REG_ORA: begin
                  out_a_in = v;
                  ifr_in[1:0] = 2'b00;
               end
               REG_DDRB: dir_b_in = v;
               REG_DDRA: dir_a_in = v;
               REG_T1CL, REG_T1LL: t1_latch_in[7:0] = v;
               REG_T1CH: begin
                  t1_latch_in[15:8] = v;
                  t1_cnt_in = $signed({2'b00, v, t1_latch_ff[7:0], 1'b0});
                  ifr_in[6] = 1'b0;
                  t1_fired_in = 1'b0;
                  if (acr_ff[7]) begin
                     out_b_in[7] = 1'b0;
                     pins_b_in[7] = 1'b0;
                  end
               end
               REG_T1LH: t1_latch_in[15:8] = v;
               REG_T2CL: t2_latch_in[7:0] = v;
               REG_T2CH: begin
                  t2_latch_in[15:8] = v;
                  t2_cnt_in = $signed({2'b00, v, t2_latch_ff[7:0], 1'b0});
                  ifr_in[5] = 1'b0;
               end
               REG_ACR: acr_in = v;
               REG_PCR: pcr_in = v;
               REG_IFR: ifr_in = ifr_ff & ~v;
               REG_IER: ier_in = v[7] ? (ier_ff | v[6:0]) : (ier_ff & ~v[6:0]);
               REG_ORANH: out_a_in = v;
               default: ;
            endcase
         end
         CMD_READ: begin
            case (req_data.address)
               REG_ORB: begin
                  rd = (out_b_ff & dir_b_ff) | (pins_b_ff & ~dir_b_ff);
                  if (mouse_en_ff) begin
                     if (both_mid_ff) begin
                        if (b[0] && b[2]) b = 3'b010;
                        else b[1] = 1'b0;
                     end
                     rd = {~b, rd[4:0]};
                     ifr_in[4:3] = 2'b00;
                  end
               end
               REG_ORA: ifr_in[1:0] = 2'b00;
               REG_DDRB: rd = dir_b_ff;
               REG_DDRA: rd = dir_a_ff;
               REG_T1CL: begin
                  ifr_in[6] = 1'b0;
                  rd = (t1_cnt_ff <= l1x2) ? t1_h[7:0] : 8'hff;
               end
               REG_T1CH: rd = (t1_cnt_ff <= l1x2) ? t1_k[7:0] : 8'hff;
               REG_T1LL: rd = t1_latch_ff[7:0];
               REG_T1LH: rd = t1_latch_ff[15:8];
               REG_T2CL: begin
                  ifr_in[5] = 1'b0;
                  rd = (t2_cnt_ff <= l2x2) ? t2_h[7:0] : 8'hff;
               end
               REG_T2CH: rd = (t2_cnt_ff <= l2x2) ? t2_k[7:0] : 8'hff;
               REG_PCR: rd = pcr_ff;
               REG_IFR: rd = ifr_ff;
               REG_IER: rd = {1'b1, ier_ff};
               default: rd = 8'hff;
            endcase
         end
         CMD_TICK: begin
            t1_cnt_in = c1[CNT_W-1:0];
            t2_cnt_in = c2[CNT_W-1:0];
            if (c1 < 0) begin
               t1_cnt_in = (n1 < 0) ? '0 : n1[CNT_W-1:0];
               if (!t1_fired_ff || acr_ff[6]) begin
                  ifr_in[6] = 1'b1;
                  if (acr_ff[7]) begin
                     out_b_in[7] = ~out_b_ff[7];
                     pins_b_in[7] = ~pins_b_ff[7];
                  end
               end
               t1_fired_in = 1'b1;
            end
            if (c2 < 0) begin
               t2_cnt_in = CNT_W'(l2x2 - c2 - 20'sd3 - $signed({19'd0, t2_phase_ff}));
               t2_phase_in = ~t2_phase_ff;
               ifr_in[5] = 1'b1;
            end
         end
         CMD_CA1: ifr_in[1] = 1'b1;
         CMD_MOUSE: begin
            if (mouse_en_ff && ifr_ff[4:3] == 2'b00) begin
               if (req_data.target_x != mx_ff) begin
                  ifr_in[4] = 1'b1;
                  if (req_data.target_x < mx_ff) begin
                     pins_b_in[0] = 1'b0;
                     mx_in = mx_ff - 16'sd1;
                  end else begin
                     pins_b_in[0] = 1'b1;
                     mx_in = mx_ff + 16'sd1;
                  end
               end
               if (req_data.target_y != my_ff) begin
                  ifr_in[3] = 1'b1;
                  if (req_data.target_y > my_ff) begin
                     pins_b_in[2] = 1'b0;
                     my_in = my_ff + 16'sd1;
                  end else begin
                     pins_b_in[2] = 1'b1;
                     my_in = my_ff - 16'sd1;
                  end
               end
            end
         end
         default: ;
      endcase
      ifr_in[7] = |(ifr_in[6:0] & ier_in);
      if (req_data.command == CMD_READ && req_data.address == REG_IFR) rd = ifr_in;
      rsp_in.read_data     = rd;
      rsp_in.irq           = ifr_in[7];
      rsp_in.port_a_out    = out_a_in;
      rsp_in.port_b_out    = out_b_in;
      rsp_in.mouse_pending = mouse_en_ff &&
                             (req_data.target_x != mx_in || req_data.target_y != my_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mouse_en_ff <= 1'b0; both_mid_ff <= 1'b0;
         out_a_ff <= '0; out_b_ff <= '0; pins_b_ff <= 8'hff;
         dir_a_ff <= '0; dir_b_ff <= '0; acr_ff <= '0; pcr_ff <= '0;
         ier_ff <= '0; ifr_ff <= '0;
         t1_latch_ff <= 16'hffff; t2_latch_ff <= 16'hffff;
         t1_cnt_ff <= CNT_W'(131070); t2_cnt_ff <= CNT_W'(131070);
         t1_fired_ff <= 1'b0; t2_phase_ff <= 1'b0;
         mx_ff <= '0; my_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MOUSE_ENABLE) mouse_en_ff <= csr_wdata;
            if (csr_index == CSR_BOTH_MIDDLE) both_mid_ff <= csr_wdata;
         end
         if (accept) begin
            out_a_ff <= out_a_in; out_b_ff <= out_b_in; pins_b_ff <= pins_b_in;
            dir_a_ff <= dir_a_in; dir_b_ff <= dir_b_in; acr_ff <= acr_in; pcr_ff <= pcr_in;
            ier_ff <= ier_in; ifr_ff <= ifr_in;
            t1_latch_ff <= t1_latch_in; t2_latch_ff <= t2_latch_in;
            t1_cnt_ff <= t1_cnt_in; t2_cnt_ff <= t2_cnt_in;
            t1_fired_ff <= t1_fired_in; t2_phase_ff <= t2_phase_in;
            mx_ff <= mx_in; my_ff <= my_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

endmodule
